// ===== rtl/mexp_pkg.sv =====
package mexp_pkg;

    // Prime modulus; fits in 30 bits.
    localparam logic [29:0] MOD_P = 30'd1000000007;

    // Barrett constant floor(2^60 / MOD_P).
    localparam logic [30:0] BARRETT_MU = 31'd1152921496;

    // Request to the shared modular multiplier.
    typedef struct packed {
        logic        start;
        logic [29:0] op_a;
        logic [29:0] op_b;
    } mexp_mm_req_t;

    // Response from the shared modular multiplier.
    typedef struct packed {
        logic        done;
        logic [29:0] result;
    } mexp_mm_rsp_t;

    // Bring a value below 3 * MOD_P into 0 .. MOD_P-1.
    function automatic logic [29:0] reduce_3p(input logic [31:0] value);
        logic [31:0] p1;
        logic [31:0] p2;
        logic [31:0] diff;
        p1 = {2'b00, MOD_P};
        p2 = {1'b0, MOD_P, 1'b0};
        if (value < p1)
        begin
            diff = value;
        end
        else if (value < p2)
        begin
            diff = value - p1;
        end
        else
        begin
            diff = value - p2;
        end
        return diff[29:0];
    endfunction

endpackage

// ===== rtl/mexp_mulmod.sv =====
module mexp_mulmod
    import mexp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  mexp_mm_req_t req,
    output mexp_mm_rsp_t rsp
);

    typedef enum logic [5:0] {
        M_IDLE = 6'b000001,
        M_MUL  = 6'b000010,
        M_EST  = 6'b000100,
        M_QP   = 6'b001000,
        M_SUB  = 6'b010000,
        M_FIX  = 6'b100000
    } mm_state_t;

    mm_state_t   state_reg;
    mm_state_t   state_next;

    logic [29:0] a_reg;
    logic [29:0] b_reg;
    logic [59:0] x_reg;
    logic [30:0] q_reg;
    logic [31:0] r_reg;

    logic [31:0] op_x;
    logic [31:0] op_y;
    logic [63:0] mul_out;

    // Steer the one 32x32 multiplier: product, quotient estimate, quotient times modulus.
    always_comb
    begin
        unique case (state_reg)
            M_MUL:
            begin
                op_x = {2'b00, a_reg};
                op_y = {2'b00, b_reg};
            end
            M_EST:
            begin
                op_x = {1'b0, x_reg[59:29]};
                op_y = {1'b0, BARRETT_MU};
            end
            M_QP:
            begin
                op_x = {1'b0, q_reg};
                op_y = {2'b00, MOD_P};
            end
            default:
            begin
                op_x = 32'd0;
                op_y = 32'd0;
            end
        endcase
    end

    assign mul_out = {32'd0, op_x} * {32'd0, op_y};

    always_comb
    begin
        unique case (state_reg)
            M_IDLE:  state_next = req.start ? M_MUL : M_IDLE;
            M_MUL:   state_next = M_EST;
            M_EST:   state_next = M_QP;
            M_QP:    state_next = M_SUB;
            M_SUB:   state_next = M_FIX;
            M_FIX:   state_next = M_IDLE;
            default: state_next = M_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == M_IDLE && req.start)
        begin
            a_reg <= req.op_a;
            b_reg <= req.op_b;
        end
        if (state_reg == M_MUL)
        begin
            x_reg <= mul_out[59:0];
        end
        if (state_reg == M_EST)
        begin
            q_reg <= mul_out[61:31];
        end
        if (state_reg == M_QP)
        begin
            r_reg <= mul_out[31:0];
        end
        if (state_reg == M_SUB)
        begin
            // Remainder is below 3 * MOD_P, so 32 low bits carry it exactly.
            r_reg <= x_reg[31:0] - r_reg;
        end
    end

    always_comb
    begin
        rsp.done   = (state_reg == M_FIX);
        rsp.result = reduce_3p(r_reg);
    end

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == M_IDLE)
        else $error("mulmod started while busy");

    a_sub_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == M_SUB |=> rsp.done)
        else $error("mulmod did not finish after subtract");

    a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> rsp.result < MOD_P)
        else $error("mulmod result not reduced");

endmodule

// ===== rtl/modular_exponentiation_top.sv =====
// Computes base^exponent mod 1000000007 by right-to-left square-and-multiply.
// One item is in flight at a time: item_ready is high only while the block is idle.
// The base is first folded below the modulus, then each exponent bit from the
// least significant up costs one modular multiply into the accumulator when set,
// and one squaring as long as higher bits remain. Every modular multiply runs on
// a single shared 32x32 multiplier with Barrett reduction. An exponent of zero
// gives 1 for any base. The result waits in an output register, so the next
// item may be transferred while it is still unclaimed.
module modular_exponentiation_top
    import mexp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [30:0] base,
    input  logic [30:0] exponent,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [29:0] power_mod
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_REDUCE   = 7'b0000010,
        S_ACC      = 7'b0000100,
        S_ACC_WAIT = 7'b0001000,
        S_SQR      = 7'b0010000,
        S_SQR_WAIT = 7'b0100000,
        S_FINISH   = 7'b1000000
    } state_t;

    state_t       state_reg;
    state_t       state_next;

    logic [29:0]  acc_reg;      // running product
    logic [30:0]  sq_reg;       // running square (raw base until folded)
    logic [30:0]  exp_reg;      // exponent bits still to scan
    logic [29:0]  power_mod_reg;
    logic         result_valid_reg;
    logic         result_valid_next;
    logic         out_free;

    mexp_mm_req_t mm_req;
    mexp_mm_rsp_t mm_rsp;

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign power_mod    = power_mod_reg;

    // Output slot may take a new result when empty or drained this cycle.
    assign out_free = !result_valid_reg || result_ready;

    always_comb
    begin
        mm_req.start = (state_reg == S_ACC) || (state_reg == S_SQR);
        mm_req.op_a  = (state_reg == S_ACC) ? acc_reg : sq_reg[29:0];
        mm_req.op_b  = sq_reg[29:0];
    end

    mexp_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mm_req),
        .rsp   (mm_rsp)
    );

    // Sequencer: multiply on a set bit, square while higher bits remain.
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                state_next = item_valid ? S_REDUCE : S_IDLE;
            end
            S_REDUCE:
            begin
                if (exp_reg == 31'd0)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = exp_reg[0] ? S_ACC : S_SQR;
                end
            end
            S_ACC:
            begin
                state_next = S_ACC_WAIT;
            end
            S_ACC_WAIT:
            begin
                if (!mm_rsp.done)
                begin
                    state_next = S_ACC_WAIT;
                end
                else
                begin
                    // Skip the trailing square once no higher bit is left.
                    state_next = (exp_reg[30:1] == 30'd0) ? S_FINISH : S_SQR;
                end
            end
            S_SQR:
            begin
                state_next = S_SQR_WAIT;
            end
            S_SQR_WAIT:
            begin
                if (!mm_rsp.done)
                begin
                    state_next = S_SQR_WAIT;
                end
                else
                begin
                    // Next bit to scan is exp_reg[1]; higher bits are known nonzero.
                    state_next = exp_reg[1] ? S_ACC : S_SQR;
                end
            end
            S_FINISH:
            begin
                state_next = out_free ? S_IDLE : S_FINISH;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (state_reg == S_FINISH && out_free)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && item_valid)
        begin
            sq_reg  <= base;
            exp_reg <= exponent;
            acc_reg <= 30'd1;
        end
        if (state_reg == S_REDUCE)
        begin
            // Base is below 2^31, which is under three times the modulus.
            sq_reg <= {1'b0, reduce_3p({1'b0, sq_reg})};
        end
        if (state_reg == S_ACC_WAIT && mm_rsp.done)
        begin
            acc_reg <= mm_rsp.result;
        end
        if (state_reg == S_SQR_WAIT && mm_rsp.done)
        begin
            sq_reg  <= {1'b0, mm_rsp.result};
            exp_reg <= exp_reg >> 1;
        end
        if (state_reg == S_FINISH && out_free)
        begin
            power_mod_reg <= acc_reg;
        end
    end

    a_transfer_starts: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> state_reg == S_REDUCE)
        else $error("transfer did not start the reduction");

    a_finish_posts: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FINISH && !result_valid_reg |=> result_valid_reg)
        else $error("finished result not posted");

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> power_mod < MOD_P)
        else $error("result not reduced");

endmodule
